// ===== sv/itf_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, codes, descriptor type and character helpers for the integer text formatter.
package itf_pkg;

   localparam int ITF_CMD_W       = 2;
   localparam int ITF_VALUE_W     = 32;
   localparam int ITF_WIDTH_W     = 7;
   localparam int ITF_PREC_W      = 6;
   localparam int ITF_CHAR_W      = 8;
   localparam int ITF_DIGIT_W     = 4;

   localparam int ITF_MAX_FIELD   = 64;
   localparam int ITF_MAX_PREC    = 60;
   localparam int ITF_MAX_RESULTS = 64;
   localparam int ITF_DIGIT_SLOTS = 10;
   localparam int ITF_DIGIT_IDX_W = $clog2(ITF_DIGIT_SLOTS);
   localparam int ITF_COUNT_W     = $clog2(ITF_DIGIT_SLOTS + 1);
   localparam int ITF_POS_W       = ITF_WIDTH_W;

   localparam int ITF_QUEUE_DEPTH = 2;
   localparam int ITF_QUEUE_IDX_W = $clog2(ITF_QUEUE_DEPTH);

   // floor(n / 10) == (n * ITF_DEC_RECIP) >> ITF_DEC_SHIFT for every 32-bit n
   localparam logic [ITF_VALUE_W-1:0] ITF_DEC_RECIP = 32'hCCCC_CCCD;
   localparam int                     ITF_DEC_SHIFT = 35;

   localparam logic [ITF_CHAR_W-1:0] ITF_CH_ZERO  = 8'h30;
   localparam logic [ITF_CHAR_W-1:0] ITF_CH_SPACE = 8'h20;
   localparam logic [ITF_CHAR_W-1:0] ITF_CH_PLUS  = 8'h2B;
   localparam logic [ITF_CHAR_W-1:0] ITF_CH_MINUS = 8'h2D;
   localparam logic [ITF_CHAR_W-1:0] ITF_CH_X_LO  = 8'h78;
   localparam logic [ITF_CHAR_W-1:0] ITF_CH_X_UP  = 8'h58;
   localparam logic [ITF_CHAR_W-1:0] ITF_CH_A_LO  = 8'h61;
   localparam logic [ITF_CHAR_W-1:0] ITF_CH_A_UP  = 8'h41;

   typedef enum logic [ITF_CMD_W-1:0] {
      ITF_CMD_SDEC = 2'd0,
      ITF_CMD_UDEC = 2'd1,
      ITF_CMD_HEXL = 2'd2,
      ITF_CMD_HEXU = 2'd3
   } itf_cmd_type;

   typedef enum logic [2:0] {
      ITF_ST_IDLE,
      ITF_ST_CONVERT,
      ITF_ST_SIZE,
      ITF_ST_PLACE,
      ITF_ST_EMIT
   } itf_state_type;

   typedef struct packed {
      logic [ITF_VALUE_W-1:0] mag;
      logic                   hex;
      logic                   upper;
      logic [ITF_CHAR_W-1:0]  sign_char;
      logic [1:0]             pre_len;
      logic                   blank;
      logic [ITF_WIDTH_W-1:0] width;
      logic [ITF_PREC_W-1:0]  prec;
      logic                   left;
      logic                   pad_after;
      logic                   pad_zero;
   } itf_desc_type;

   function automatic logic [ITF_CHAR_W-1:0] itf_digit_char(input logic [ITF_DIGIT_W-1:0] d,
                                                            input logic upper);
      logic [ITF_CHAR_W-1:0] ext;
      ext = ITF_CHAR_W'(d);
      if (d < ITF_DIGIT_W'(10)) begin
         return ITF_CH_ZERO + ext;
      end else begin
         return (upper ? ITF_CH_A_UP : ITF_CH_A_LO) + ext - ITF_CHAR_W'(10);
      end
   endfunction

endpackage

// ===== sv/itf_if.sv =====
`timescale 1ns / 1ps
// Request and response channel interfaces for the integer text formatter.
interface itf_req_if;
   import itf_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [ITF_CMD_W-1:0]   cmd;
   logic [ITF_VALUE_W-1:0] value;
   logic [ITF_WIDTH_W-1:0] field_width;
   logic [ITF_PREC_W-1:0]  prec_digits;
   logic                   has_precision;
   logic                   left_justify;
   logic                   zero_flag;
   logic                   plus_flag;
   logic                   space_flag;
   logic                   alt_form;
   logic                   pad_is_zero;

   modport source (
      output valid, cmd, value, field_width, prec_digits, has_precision, left_justify,
             zero_flag, plus_flag, space_flag, alt_form, pad_is_zero,
      input  ready
   );

   modport sink (
      input  valid, cmd, value, field_width, prec_digits, has_precision, left_justify,
             zero_flag, plus_flag, space_flag, alt_form, pad_is_zero,
      output ready
   );
endinterface

interface itf_rsp_if;
   import itf_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ITF_CHAR_W-1:0] out_char;
   logic                  last;

   modport source (output valid, out_char, last, input ready);
   modport sink (input valid, out_char, last, output ready);
endinterface

// ===== sv/itf_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts requests, resolves sign, prefix, pad and precision into a descriptor.
module itf_front #(
   parameter int MAX_FIELD = itf_pkg::ITF_MAX_FIELD
) (
   itf_req_if.sink              req_chan,
   output logic                 push_valid,
   input  logic                 push_ready,
   output itf_pkg::itf_desc_type push_desc
);
   import itf_pkg::*;

   itf_cmd_type cmd;
   logic        neg;
   logic        blank;
   logic        value_zero;

   assign cmd        = itf_cmd_type'(req_chan.cmd);
   assign value_zero = (req_chan.value == '0);
   assign neg        = (cmd == ITF_CMD_SDEC) && req_chan.value[ITF_VALUE_W-1];
   // zero value with explicit zero precision prints no digits at all
   assign blank      = req_chan.has_precision && (req_chan.prec_digits == '0) && value_zero;

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

   always_comb begin
      push_desc           = '0;
      push_desc.mag       = neg ? ('0 - req_chan.value) : req_chan.value;
      push_desc.hex       = (cmd == ITF_CMD_HEXL) || (cmd == ITF_CMD_HEXU);
      push_desc.upper     = (cmd == ITF_CMD_HEXU);
      push_desc.blank     = blank;
      push_desc.left      = req_chan.left_justify;
      push_desc.pad_after = req_chan.zero_flag && !req_chan.has_precision;
      push_desc.pad_zero  = req_chan.pad_is_zero && !blank;

      if (int'(req_chan.field_width) > MAX_FIELD) begin
         push_desc.width = ITF_WIDTH_W'(MAX_FIELD);
      end else begin
         push_desc.width = req_chan.field_width;
      end

      if (!req_chan.has_precision) begin
         push_desc.prec = '0;
      end else if (int'(req_chan.prec_digits) > ITF_MAX_PREC) begin
         push_desc.prec = ITF_PREC_W'(ITF_MAX_PREC);
      end else begin
         push_desc.prec = req_chan.prec_digits;
      end

      push_desc.sign_char = ITF_CH_SPACE;
      push_desc.pre_len   = 2'd0;
      if (!blank) begin
         if (cmd == ITF_CMD_SDEC) begin
            if (neg) begin
               push_desc.sign_char = ITF_CH_MINUS;
               push_desc.pre_len   = 2'd1;
            end else if (req_chan.plus_flag) begin
               push_desc.sign_char = ITF_CH_PLUS;
               push_desc.pre_len   = 2'd1;
            end else if (req_chan.space_flag) begin
               push_desc.pre_len   = 2'd1;
            end
         end else if (push_desc.hex && req_chan.alt_form && !value_zero) begin
            push_desc.pre_len = 2'd2;
         end
      end
   end

endmodule

// ===== sv/itf_queue.sv =====
`timescale 1ns / 1ps
// Short descriptor queue between the front end and the emit engine.
module itf_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  itf_pkg::itf_desc_type push_desc,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output itf_pkg::itf_desc_type pop_desc
);
   import itf_pkg::*;

   localparam int CNT_W = $clog2(ITF_QUEUE_DEPTH + 1);

   itf_desc_type               entry_ff [ITF_QUEUE_DEPTH];
   logic [ITF_QUEUE_IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ITF_QUEUE_IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(ITF_QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_desc   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ITF_QUEUE_IDX_W'(ITF_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ITF_QUEUE_IDX_W'(ITF_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== sv/itf_back.sv =====
`timescale 1ns / 1ps
// Back end: converts the magnitude to digits, lays out the text and emits one character a cycle when not stalled.
module itf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  pop_valid,
   output logic                  pop_ready,
   input  itf_pkg::itf_desc_type pop_desc,
   itf_rsp_if.source             rsp_chan
);
   import itf_pkg::*;

   itf_state_type state_ff, state_in;

   itf_desc_type           desc_ff, desc_in;
   logic [ITF_VALUE_W-1:0] mag_ff, mag_in;
   logic [ITF_DIGIT_W-1:0] digit_store_ff [ITF_DIGIT_SLOTS];
   logic                   digit_we;
   logic [ITF_DIGIT_W-1:0] digit_wdata;
   logic [ITF_COUNT_W-1:0] digit_count_ff, digit_count_in;
   logic [ITF_DIGIT_IDX_W-1:0] rd_idx_ff, rd_idx_in;

   logic [ITF_POS_W-1:0] zeros_ff, zeros_in;
   logic [ITF_POS_W-1:0] pad_ff, pad_in;
   logic [ITF_POS_W-1:0] b_lead_ff, b_lead_in;
   logic [ITF_POS_W-1:0] b_pre_ff, b_pre_in;
   logic [ITF_POS_W-1:0] b_mid_ff, b_mid_in;
   logic [ITF_POS_W-1:0] b_zero_ff, b_zero_in;
   logic [ITF_POS_W-1:0] b_dig_ff, b_dig_in;
   logic [ITF_POS_W-1:0] last_pos_ff, last_pos_in;
   logic [ITF_POS_W-1:0] pos_ff, pos_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ITF_CHAR_W-1:0] rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   // digit step
   logic [2*ITF_VALUE_W-1:0] prod;
   logic [ITF_VALUE_W-1:0]   quot;
   logic [ITF_VALUE_W-1:0]   quot_x10;
   logic [ITF_VALUE_W-1:0]   rem_full;

   // layout
   logic [ITF_POS_W-1:0] digits_ext;
   logic [ITF_POS_W-1:0] prec_ext;
   logic [ITF_POS_W-1:0] eff_prec;
   logic [ITF_POS_W-1:0] need;
   logic [ITF_POS_W-1:0] lead, mid, trail;
   logic [ITF_POS_W:0]   total;
   logic [ITF_POS_W:0]   capped;

   logic                  advance;
   logic [ITF_CHAR_W-1:0] pad_char;

   assign prod     = mag_ff * ITF_DEC_RECIP;
   assign quot     = desc_ff.hex ? (mag_ff >> 4) : ITF_VALUE_W'(prod >> ITF_DEC_SHIFT);
   assign quot_x10 = (quot << 3) + (quot << 1);
   assign rem_full = mag_ff - quot_x10;

   assign digits_ext = ITF_POS_W'(digit_count_ff);
   assign prec_ext   = ITF_POS_W'(desc_ff.prec);
   assign eff_prec   = (prec_ext > digits_ext) ? prec_ext : digits_ext;
   assign need       = eff_prec + ITF_POS_W'(desc_ff.pre_len);

   assign lead  = (!desc_ff.left && !desc_ff.pad_after) ? pad_ff : '0;
   assign mid   = (!desc_ff.left && desc_ff.pad_after) ? pad_ff : '0;
   assign trail = desc_ff.left ? pad_ff : '0;
   assign total = (ITF_POS_W + 1)'(b_dig_in) + (ITF_POS_W + 1)'(trail);
   assign capped = (total > (ITF_POS_W + 1)'(ITF_MAX_RESULTS)) ?
                   (ITF_POS_W + 1)'(ITF_MAX_RESULTS) : total;

   assign pad_char = desc_ff.pad_zero ? ITF_CH_ZERO : ITF_CH_SPACE;
   assign advance  = !rsp_valid_ff || rsp_chan.ready;

   assign pop_ready         = (state_ff == ITF_ST_IDLE);
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_char = rsp_char_ff;
   assign rsp_chan.last     = rsp_last_ff;

   always_comb begin
      state_in       = state_ff;
      desc_in        = desc_ff;
      mag_in         = mag_ff;
      digit_we       = 1'b0;
      digit_wdata    = desc_ff.hex ? mag_ff[ITF_DIGIT_W-1:0] : rem_full[ITF_DIGIT_W-1:0];
      digit_count_in = digit_count_ff;
      rd_idx_in      = rd_idx_ff;
      zeros_in       = zeros_ff;
      pad_in         = pad_ff;
      b_lead_in      = lead;
      b_pre_in       = lead + ITF_POS_W'(desc_ff.pre_len);
      b_mid_in       = b_pre_in + mid;
      b_zero_in      = b_mid_in + zeros_ff;
      b_dig_in       = b_zero_in + digits_ext;
      last_pos_in    = last_pos_ff;
      pos_in         = pos_ff;
      rsp_char_in    = rsp_char_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;

      unique case (state_ff)
         ITF_ST_IDLE: begin
            if (pop_valid) begin
               desc_in        = pop_desc;
               mag_in         = pop_desc.mag;
               digit_count_in = '0;
               state_in       = pop_desc.blank ? ITF_ST_SIZE : ITF_ST_CONVERT;
            end
         end

         ITF_ST_CONVERT: begin
            // one digit per cycle, least significant first
            digit_we       = 1'b1;
            digit_count_in = digit_count_ff + 1'b1;
            mag_in         = quot;
            if (quot == '0) begin
               state_in = ITF_ST_SIZE;
            end
         end

         ITF_ST_SIZE: begin
            zeros_in  = eff_prec - digits_ext;
            pad_in    = (ITF_POS_W'(desc_ff.width) > need) ?
                        ITF_POS_W'(desc_ff.width) - need : '0;
            rd_idx_in = ITF_DIGIT_IDX_W'(digit_count_ff - 1'b1);
            state_in  = ITF_ST_PLACE;
         end

         ITF_ST_PLACE: begin
            pos_in = '0;
            if (capped == '0) begin
               state_in = ITF_ST_IDLE;
            end else begin
               last_pos_in = ITF_POS_W'(capped - 1'b1);
               state_in    = ITF_ST_EMIT;
            end
         end

         ITF_ST_EMIT: begin
            if (advance) begin
               rsp_valid_in = 1'b1;
               rsp_last_in  = (pos_ff == last_pos_ff);
               pos_in       = pos_ff + 1'b1;
               priority if (pos_ff < b_lead_ff) begin
                  rsp_char_in = pad_char;
               end else if (pos_ff < b_pre_ff) begin
                  if (desc_ff.pre_len == 2'd1) begin
                     rsp_char_in = desc_ff.sign_char;
                  end else if (pos_ff == b_lead_ff) begin
                     rsp_char_in = ITF_CH_ZERO;
                  end else begin
                     rsp_char_in = desc_ff.upper ? ITF_CH_X_UP : ITF_CH_X_LO;
                  end
               end else if (pos_ff < b_mid_ff) begin
                  rsp_char_in = pad_char;
               end else if (pos_ff < b_zero_ff) begin
                  rsp_char_in = ITF_CH_ZERO;
               end else if (pos_ff < b_dig_ff) begin
                  // read digits back most significant first
                  rsp_char_in = itf_digit_char(digit_store_ff[rd_idx_ff], desc_ff.upper);
                  rd_idx_in   = rd_idx_ff - 1'b1;
               end else begin
                  rsp_char_in = ITF_CH_SPACE;
               end
               if (pos_ff == last_pos_ff) begin
                  state_in = ITF_ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ITF_ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ITF_ST_IDLE;
         digit_count_ff <= '0;
         pos_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         digit_count_ff <= digit_count_in;
         pos_ff         <= pos_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      mag_ff      <= mag_in;
      rd_idx_ff   <= rd_idx_in;
      zeros_ff    <= zeros_in;
      pad_ff      <= pad_in;
      last_pos_ff <= last_pos_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == ITF_ST_PLACE) begin
         b_lead_ff <= b_lead_in;
         b_pre_ff  <= b_pre_in;
         b_mid_ff  <= b_mid_in;
         b_zero_ff <= b_zero_in;
         b_dig_ff  <= b_dig_in;
      end
      if (digit_we) begin
         digit_store_ff[digit_count_ff[ITF_DIGIT_IDX_W-1:0]] <= digit_wdata;
      end
   end

endmodule

// ===== sv/integer_text_formatter_core.sv =====
`timescale 1ns / 1ps
// Top level of the integer text formatter: front end, descriptor queue and emit engine.
//
//   channel    dir   handshake          payload
//   req_chan   in    valid / ready      cmd, value, field_width, prec_digits, flags
//   rsp_chan   out   valid / ready      out_char, last
//
// A request leaves the queue when the back end is idle, is converted one digit per cycle (1 to 10
// decimal, 1 to 8 hex; none for a blank zero) in the shared divide-by-base step, is laid out in the
// SIZE and PLACE states, then is emitted one character per cycle while rsp_chan is not stalled (at most 64).
// The front end accepts requests into a two-entry queue while the back end works.
// Reset is synchronous and clears the queue and the emit state.
// A stalled rsp_chan holds the registered character; the back end waits with it.
module integer_text_formatter_core #(
   parameter int MAX_FIELD = itf_pkg::ITF_MAX_FIELD
) (
   input  logic      clock,
   input  logic      reset,
   itf_req_if.sink   req_chan,
   itf_rsp_if.source rsp_chan
);
   import itf_pkg::*;

   logic         push_valid, push_ready;
   logic         pop_valid, pop_ready;
   itf_desc_type push_desc, pop_desc;

   itf_front #(
      .MAX_FIELD (MAX_FIELD)
   ) u_front (
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc)
   );

   itf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_desc   (pop_desc)
   );

   itf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_desc  (pop_desc),
      .rsp_chan  (rsp_chan)
   );

endmodule
